// File: src/wspp_pkg.sv
// shared types, constants, arithmetic helpers and the control program
`timescale 1ns / 1ps
package wspp_pkg;

    localparam int PULSE_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int LIMIT_W   = 16;
    localparam int SPEED_W   = 32;
    localparam int ERR_W     = 33;
    localparam int DIFF_W    = 34;
    localparam int PROD_W    = 64;
    localparam int TERM_W    = 42;
    localparam int INTEG_W   = 40;
    localparam int ACC_W     = 43;
    localparam int CLAMP_W   = 33;
    localparam int WARM_W    = 3;

    localparam logic [WARM_W-1:0] WARMUP_STEPS = 3'd6;
    localparam logic [TERM_W-2:0] TERM_CAP     = 41'd1 << 40;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd5;

    localparam logic [CFG_W-1:0]   RST_SCALE = 32'd990000;
    localparam logic [CFG_W-1:0]   RST_KP    = 32'd5242880;
    localparam logic [CFG_W-1:0]   RST_KI    = 32'd5243;
    localparam logic [LIMIT_W-1:0] RST_LIMIT = 16'd1000;

    localparam int UCODE_DEPTH = 11;
    localparam int STEP_W      = $clog2(UCODE_DEPTH);

    // jump targets
    localparam logic [STEP_W-1:0] S_WARM  = 4'd7;
    localparam logic [STEP_W-1:0] S_MUL_D = 4'd8;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_MUL_SPD,
        OP_SPEED,
        OP_ERR,
        OP_MUL_P,
        OP_TERM_P,
        OP_MUL_I,
        OP_INTEG,
        OP_WARM,
        OP_MUL_D,
        OP_SUM,
        OP_OUT
    } t_op;

    typedef enum logic [1:0] {
        BR_NONE,
        BR_ALWAYS,
        BR_WARMUP
    } t_br;

    typedef struct packed {
        t_op               op;
        t_br               br;
        logic [STEP_W-1:0] tgt;
        logic              last;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic en;
    } t_ctrl;

    typedef struct packed {
        logic warming;
    } t_stat;

    typedef struct packed {
        logic signed [CFG_W-1:0] target;
        logic [CFG_W-1:0]        scale;
        logic [CFG_W-1:0]        kp;
        logic [CFG_W-1:0]        ki;
        logic [CFG_W-1:0]        kd;
        logic [LIMIT_W-1:0]      limit;
    } t_cfg;

    typedef struct packed {
        logic [LIMIT_W-1:0]        duty;
        logic                      fwd;
        logic signed [SPEED_W-1:0] speed;
    } t_res;

    // control program, one word per step
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{op: OP_NOP, br: BR_NONE, tgt: '0, last: 1'b0};
        unique case (step)
            4'd0:  w.op = OP_MUL_SPD;
            4'd1:  w.op = OP_SPEED;
            4'd2:  w.op = OP_ERR;
            4'd3:  w.op = OP_MUL_P;
            4'd4:  w = '{op: OP_TERM_P, br: BR_WARMUP, tgt: S_WARM, last: 1'b0};
            4'd5:  w.op = OP_MUL_I;
            4'd6:  w = '{op: OP_INTEG, br: BR_ALWAYS, tgt: S_MUL_D, last: 1'b0};
            4'd7:  w.op = OP_WARM;
            4'd8:  w.op = OP_MUL_D;
            4'd9:  w.op = OP_SUM;
            4'd10: w = '{op: OP_OUT, br: BR_NONE, tgt: '0, last: 1'b1};
            default: w = '{op: OP_NOP, br: BR_NONE, tgt: '0, last: 1'b1};
        endcase
        return w;
    endfunction

    // (mag * gain) >> 16, saturated at 2^40, then signed
    function automatic logic signed [TERM_W-1:0] term_sat(
        input logic [PROD_W-1:0] prod,
        input logic              big,
        input logic              gz,
        input logic              neg
    );
        logic [PROD_W-17:0] shr;
        logic [TERM_W-2:0]  m;
        shr = prod[PROD_W-1:16];
        if (gz) begin
            m = '0;
        end else if (big || shr > {7'b0, TERM_CAP}) begin
            m = TERM_CAP;
        end else begin
            m = shr[TERM_W-2:0];
        end
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    // symmetric clamp to +-(limit << 16)
    function automatic logic signed [CLAMP_W-1:0] clamp_sym(
        input logic signed [ACC_W-1:0] v,
        input logic [LIMIT_W-1:0]      lim
    );
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = $signed({11'b0, lim, 16'b0});
        lo = -hi;
        if (v > hi) begin
            return hi[CLAMP_W-1:0];
        end else if (v < lo) begin
            return lo[CLAMP_W-1:0];
        end
        return v[CLAMP_W-1:0];
    endfunction

endpackage

// File: src/wheel_speed_pid_pwm_core.sv
// top level: config registers, handshakes and the microcode sequencer
`timescale 1ns / 1ps
// Wheel speed PID controller. Each input word carries the encoder pulse count of
// one control tick; each output word carries duty, direction and measured speed.
// Input channel: i_in_valid / o_in_stall with i_pulse_count. Output channel:
// o_out_valid / i_out_stall with o_duty, o_forward, o_measured_speed.
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is high,
// only when the block is idle. Index 0 target, 1 scale, 2 kp, 3 ki*dt,
// 4 kd/dt, 5 pwm limit; other indexes are ignored.
// One word is worked on at a time by a program of 11 steps. In the first six
// ticks the warm-up step stands in for the two integral steps. The last step
// writes the output register, which drives the outputs directly. The shared
// 32x32 multiplier is used up to four times per word. A new word is accepted
// only after the last step of the current one.
// o_in_stall is high while a word is in work. A stalled result stays in the
// output register; the next word is still accepted and runs up to its last
// step, where it waits until the slot frees.
// Reset loads the default registers, clears integral, last error and the
// warm-up count and sets the direction to forward.
module wheel_speed_pid_pwm_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [15:0]                       i_pulse_count,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [15:0]                       o_duty,
    output logic                              o_forward,
    output logic signed [31:0]                o_measured_speed,
    input  logic                              i_cfg_we,
    input  logic [wspp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wspp_pkg::CFG_W-1:0]        i_cfg_data
);
    import wspp_pkg::*;

    t_cfg                r_cfg;
    logic                r_busy;
    logic [STEP_W-1:0]   r_step;
    logic [PULSE_W-1:0]  r_pulse;
    logic                r_out_valid;
    t_res                r_res;

    t_uword              uw;
    t_ctrl               ctrl;
    t_stat               stat;
    t_res                res;
    logic                slot_free;
    logic                take_br;
    logic                accept;
    logic [STEP_W-1:0]   n_step;

    assign uw        = ucode(r_step);
    assign slot_free = ~r_out_valid | ~i_out_stall;
    assign ctrl.op   = uw.op;
    assign ctrl.en   = r_busy & ((uw.op != OP_OUT) | slot_free);
    assign accept    = i_in_valid & ~r_busy;

    always_comb begin
        unique case (uw.br)
            BR_ALWAYS: take_br = 1'b1;
            BR_WARMUP: take_br = stat.warming;
            default:   take_br = 1'b0;
        endcase
        n_step = take_br ? uw.tgt : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target <= '0;
            r_cfg.scale  <= RST_SCALE;
            r_cfg.kp     <= RST_KP;
            r_cfg.ki     <= RST_KI;
            r_cfg.kd     <= '0;
            r_cfg.limit  <= RST_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TARGET: r_cfg.target <= $signed(i_cfg_data);
                REG_SCALE:  r_cfg.scale  <= i_cfg_data;
                REG_KP:     r_cfg.kp     <= i_cfg_data;
                REG_KI:     r_cfg.ki     <= i_cfg_data;
                REG_KD:     r_cfg.kd     <= i_cfg_data;
                REG_LIMIT:  r_cfg.limit  <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy  <= 1'b1;
                r_step  <= '0;
                r_pulse <= i_pulse_count;
            end else if (ctrl.en) begin
                if (uw.last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= n_step;
                end
            end
            if (ctrl.en && uw.op == OP_OUT) begin
                r_out_valid <= 1'b1;
                r_res       <= res;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    wspp_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_cfg   (r_cfg),
        .i_pulse (r_pulse),
        .o_stat  (stat),
        .o_res   (res)
    );

    assign o_in_stall       = r_busy;
    assign o_out_valid      = r_out_valid;
    assign o_duty           = r_res.duty;
    assign o_forward        = r_res.fwd;
    assign o_measured_speed = r_res.speed;

endmodule

// File: src/wspp_dpath.sv
// datapath: shared multiplier, pid state and term arithmetic driven by control words
`timescale 1ns / 1ps
module wspp_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wspp_pkg::t_ctrl       i_ctrl,
    input  wspp_pkg::t_cfg        i_cfg,
    input  logic [15:0]           i_pulse,
    output wspp_pkg::t_stat       o_stat,
    output wspp_pkg::t_res        o_res
);
    import wspp_pkg::*;

    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ERR_W-1:0]   r_last_err;
    logic                      r_dir;
    logic [WARM_W-1:0]         r_warm_cnt;

    logic [PROD_W-1:0]         r_prod;
    logic                      r_neg;
    logic                      r_big;
    logic                      r_gz;
    logic signed [SPEED_W-1:0] r_speed;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [ACC_W-1:0]   r_acc;

    logic [CFG_W-1:0]          mul_a;
    logic [CFG_W-1:0]          mul_b;
    logic [PROD_W-1:0]         mul_p;
    logic [ERR_W-1:0]          mag_err;
    logic [DIFF_W-1:0]         mag_diff;
    logic signed [TERM_W-1:0]  term;
    logic [39:0]               smag;
    logic [30:0]               smag_sat;
    logic signed [ACC_W-1:0]   isum;
    logic signed [CLAMP_W-1:0] icl;
    logic signed [CLAMP_W-1:0] ocl;
    logic [CLAMP_W-1:0]        omag;

    assign mag_err  = r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);
    assign mag_diff = r_diff[DIFF_W-1] ? DIFF_W'(-r_diff) : DIFF_W'(r_diff);

    always_comb begin
        unique case (i_ctrl.op)
            OP_MUL_SPD: begin
                mul_a = {16'b0, i_pulse};
                mul_b = i_cfg.scale;
            end
            OP_MUL_P: begin
                mul_a = mag_err[CFG_W-1:0];
                mul_b = i_cfg.kp;
            end
            OP_MUL_I: begin
                mul_a = mag_err[CFG_W-1:0];
                mul_b = i_cfg.ki;
            end
            OP_MUL_D: begin
                mul_a = mag_diff[CFG_W-1:0];
                mul_b = i_cfg.kd;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign term  = term_sat(r_prod, r_big, r_gz, r_neg);

    assign smag     = r_prod[47:8];
    assign smag_sat = (|smag[39:31]) ? 31'h7fff_ffff : smag[30:0];

    assign isum = {{3{r_integ[INTEG_W-1]}}, r_integ} + {term[TERM_W-1], term};
    assign icl  = clamp_sym(isum, i_cfg.limit);

    assign ocl  = clamp_sym(r_acc, i_cfg.limit);
    assign omag = ocl[CLAMP_W-1] ? CLAMP_W'(-ocl) : CLAMP_W'(ocl);

    assign o_res.duty   = omag[31:16];
    assign o_res.fwd    = ~ocl[CLAMP_W-1];
    assign o_res.speed  = r_speed;
    assign o_stat.warming = (r_warm_cnt < WARMUP_STEPS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_last_err <= '0;
            r_dir      <= 1'b1;
            r_warm_cnt <= '0;
        end else if (i_ctrl.en) begin
            unique case (i_ctrl.op)
                OP_NOP: begin
                end
                OP_MUL_SPD: begin
                    r_prod <= mul_p;
                end
                OP_SPEED: begin
                    r_speed <= r_dir ? $signed({1'b0, smag_sat})
                                     : -$signed({1'b0, smag_sat});
                end
                OP_ERR: begin
                    r_err <= {i_cfg.target[CFG_W-1], i_cfg.target}
                           - {r_speed[SPEED_W-1], r_speed};
                end
                OP_MUL_P, OP_MUL_I: begin
                    r_prod <= mul_p;
                    r_neg  <= r_err[ERR_W-1];
                    r_big  <= mag_err[ERR_W-1];
                    r_gz   <= (mul_b == '0);
                end
                OP_TERM_P: begin
                    r_acc      <= {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
                    r_diff     <= {r_err[ERR_W-1], r_err}
                                - {r_last_err[ERR_W-1], r_last_err};
                    r_last_err <= r_err;
                end
                OP_INTEG: begin
                    r_integ <= {{(INTEG_W-CLAMP_W){icl[CLAMP_W-1]}}, icl};
                end
                OP_WARM: begin
                    // integral held at zero until warm-up ends
                    r_integ    <= '0;
                    r_warm_cnt <= r_warm_cnt + 1'b1;
                end
                OP_MUL_D: begin
                    r_prod <= mul_p;
                    r_neg  <= r_diff[DIFF_W-1];
                    r_big  <= |mag_diff[DIFF_W-1:DIFF_W-2];
                    r_gz   <= (mul_b == '0);
                end
                OP_SUM: begin
                    r_acc <= r_acc
                           + {{(ACC_W-INTEG_W){r_integ[INTEG_W-1]}}, r_integ}
                           + {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
                end
                OP_OUT: begin
                    r_dir <= ~ocl[CLAMP_W-1];
                end
            endcase
        end
    end

endmodule

// File: src/wspp_checker.sv
// port-level checks on the controller, bound to the top level
`timescale 1ns / 1ps
module wspp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [15:0]                    o_duty,
    input logic                           o_forward,
    input logic signed [31:0]             o_measured_speed
);

    // a stalled result holds its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_duty)
            && $stable(o_forward) && $stable(o_measured_speed))
        else $error("stalled result changed");

    // an accepted word keeps the input side busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // a new result only comes out of a word in work, which then ends
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall && $past(o_in_stall))
        else $error("result without work");

    // finishing a word always leaves a result
    a_finish_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> o_out_valid)
        else $error("work ended without result");

endmodule

bind wheel_speed_pid_pwm_core wspp_checker u_wspp_checker (.*);
